// ===== hw/rtl/rrfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rrfc_pkg - shared types and constants for the RTU response frame checker
// Status codes, result beat layout and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package rrfc_pkg;

    localparam int unsigned DEF_MAX_FRAME_BYTES = 256;

    localparam logic [15:0] CRC_START    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REF = 16'hA001;
    localparam logic [7:0]  EXC_MASK     = 8'h80;

    // header is address, function, count; trailer is the two CRC bytes
    localparam int unsigned HDR_BYTES   = 3;
    localparam int unsigned TRL_BYTES   = 2;
    localparam int unsigned MIN_FRAME   = 4;
    localparam int unsigned EXC_CONSUME = 3;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_CRC_ERR   = 2'd2,
        ST_EXCEPTION = 2'd3
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  srv_addr;
        logic [7:0]  fn_code;
        logic [7:0]  data_len;
        logic [7:0]  exc_code;
        t_status     status;
        logic [8:0]  consumed_length;
        logic [15:0] computed_crc;
    } t_result;

    // one byte into a reflected CRC-16 (poly 0xA001), bit at a time
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REF;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/rrfc_in_stage.sv =====
// ----------------------------------------------------------------------------
// rrfc_in_stage - input register
// Holds one received beat until the frame logic takes it.
// ----------------------------------------------------------------------------
module rrfc_in_stage
    import rrfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_eof,
    output logic       o_valid,
    input  logic       i_take,
    output logic [7:0] o_byte,
    output logic       o_eof
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_eof;
    logic       n_valid;

    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
            r_eof  <= i_eof;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_eof   = r_eof;

endmodule

// ===== hw/rtl/rrfc_frame_core.sv =====
// ----------------------------------------------------------------------------
// rrfc_frame_core - per-frame state and checks
// Tracks position, header bytes and the delayed CRC; builds the result beat.
// ----------------------------------------------------------------------------
module rrfc_frame_core
    import rrfc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_eof,
    output logic       o_emit,
    output t_result    o_result
);

    localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned CMP_W = (POS_W + 1 > 9) ? POS_W + 1 : 9;

    logic [POS_W-1:0] r_pos;
    logic [15:0]      r_crc;
    logic [7:0]       r_dly0, r_dly1;
    logic [7:0]       r_slave, r_func, r_third;

    logic [POS_W-1:0] n_pos;
    logic [15:0]      n_crc;
    logic [7:0]       n_dly0, n_dly1;
    logic [7:0]       n_slave, n_func, n_third;

    logic             is_exc;
    logic [CMP_W-1:0] pos_x, len_raw, length, need;
    logic [15:0]      received;
    t_status          status;
    logic [8:0]       consumed;

    always_comb begin
        n_slave = r_slave;
        n_func  = r_func;
        n_third = r_third;
        if (r_pos == POS_W'(0)) begin
            n_slave = i_byte;
        end else if (r_pos == POS_W'(1)) begin
            n_func = i_byte;
        end else if (r_pos == POS_W'(2)) begin
            n_third = i_byte;
        end

        // fold the byte two places back once it is known not to be CRC trailer
        n_crc = (r_pos >= POS_W'(2)) ? crc16_fold(r_crc, r_dly1) : r_crc;

        is_exc   = (n_func & EXC_MASK) != 8'h00;
        pos_x    = CMP_W'(r_pos);
        len_raw  = pos_x + CMP_W'(1);
        length   = (len_raw > CMP_W'(MAX_FRAME_BYTES)) ? CMP_W'(MAX_FRAME_BYTES) : len_raw;
        need     = CMP_W'(n_third) + CMP_W'(HDR_BYTES + TRL_BYTES);
        received = {i_byte, r_dly0};

        consumed = 9'd0;
        if (length < CMP_W'(MIN_FRAME)) begin
            status = ST_MALFORMED;
        end else if (is_exc) begin
            status   = ST_EXCEPTION;
            consumed = 9'(EXC_CONSUME);
        end else if (length < need) begin
            status = ST_MALFORMED;
        end else if (n_crc != received) begin
            status = ST_CRC_ERR;
        end else begin
            status   = ST_OK;
            consumed = need[8:0];
        end

        o_result = '0;
        o_emit   = 1'b0;
        if (i_eof) begin
            o_emit                   = i_fire;
            o_result.kind            = KIND_STATUS;
            o_result.srv_addr        = n_slave;
            o_result.fn_code         = n_func;
            o_result.data_len        = is_exc ? 8'h00 : n_third;
            o_result.exc_code        = is_exc ? n_third : 8'h00;
            o_result.status          = status;
            o_result.consumed_length = consumed;
            o_result.computed_crc    = n_crc;
        end else begin
            o_emit = i_fire && (r_pos >= POS_W'(HDR_BYTES))
                     && (r_pos < POS_W'(MAX_FRAME_BYTES)) && !is_exc
                     && (pos_x < CMP_W'(r_third) + CMP_W'(HDR_BYTES));
            o_result.kind         = KIND_PAYLOAD;
            o_result.payload_byte = i_byte;
        end

        n_dly0 = i_byte;
        n_dly1 = r_dly0;
        n_pos  = (r_pos < POS_W'(MAX_FRAME_BYTES)) ? r_pos + POS_W'(1) : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_eof)) begin
            r_pos   <= '0;
            r_crc   <= CRC_START;
            r_dly0  <= 8'h00;
            r_dly1  <= 8'h00;
            r_slave <= 8'h00;
            r_func  <= 8'h00;
            r_third <= 8'h00;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_dly0  <= n_dly0;
            r_dly1  <= n_dly1;
            r_slave <= n_slave;
            r_func  <= n_func;
            r_third <= n_third;
        end
    end

endmodule

// ===== hw/rtl/rrfc_out_stage.sv =====
// ----------------------------------------------------------------------------
// rrfc_out_stage - result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module rrfc_out_stage
    import rrfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;
    logic    n_valid;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/rtu_response_frame_checker_unit.sv =====
// ----------------------------------------------------------------------------
// rtu_response_frame_checker_unit - serial bus response frame checker
// Receives a response frame byte by byte, passes payload on, reports status.
// ----------------------------------------------------------------------------
// A response frame arrives one beat per byte on the input channel, with
// i_end_of_frame high on the final byte. Byte 0 is the slave address, byte 1
// the function code and byte 2 the byte count (or exception code when bit 7
// of the function code is set). Outside exception frames, payload bytes at
// positions 3 .. 3+count-1, below MAX_FRAME_BYTES, are sent out as result
// beats of kind 0 as they arrive; the final byte never is. The final byte
// produces one status beat (kind 1) carrying the header, the status (0 ok,
// 1 malformed/short, 2 CRC mismatch, 3 exception), the consumed length and
// the CRC-16/MODBUS computed over all but the last two bytes; the frame state
// then returns to its reset values. Throughput is one byte per clock while
// result beats are taken without stall: every byte passes through the input
// register, the combinational frame logic (an eight-step byte-wide CRC update
// plus length compares) and the result register, which presents the beat.
// While a result waits untaken, one more byte can enter the input register;
// it stays there until the result slot frees, and the slot frees in the same
// cycle its beat is taken, so a taken result never costs a gap.
// ----------------------------------------------------------------------------
module rtu_response_frame_checker_unit
    import rrfc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_frame,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_srv_addr,
    output logic [7:0]  o_fn_code,
    output logic [7:0]  o_data_len,
    output logic [7:0]  o_exc_code,
    output logic [1:0]  o_frame_status,
    output logic [8:0]  o_consumed_length,
    output logic [15:0] o_computed_crc
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_eof;
    logic       out_free;
    logic       fire;
    logic       emit;
    t_result    core_result;
    t_result    out_result;

    // a byte moves into the frame logic whenever the result slot can take
    // whatever it may produce
    assign fire = in_valid && out_free;

    rrfc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_byte  (i_rx_byte),
        .i_eof   (i_end_of_frame),
        .o_valid (in_valid),
        .i_take  (fire),
        .o_byte  (in_byte),
        .o_eof   (in_eof)
    );

    rrfc_frame_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (in_byte),
        .i_eof    (in_eof),
        .o_emit   (emit),
        .o_result (core_result)
    );

    rrfc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_result_kind     = out_result.kind;
    assign o_payload_byte    = out_result.payload_byte;
    assign o_srv_addr        = out_result.srv_addr;
    assign o_fn_code         = out_result.fn_code;
    assign o_data_len        = out_result.data_len;
    assign o_exc_code        = out_result.exc_code;
    assign o_frame_status    = out_result.status;
    assign o_consumed_length = out_result.consumed_length;
    assign o_computed_crc    = out_result.computed_crc;

endmodule

// ===== hw/rtl/rrfc_checker.sv =====
// ----------------------------------------------------------------------------
// rrfc_checker - port-level assertions for the frame checker
// Consistency of result beats and hold of a stalled result.
// ----------------------------------------------------------------------------
module rrfc_checker
    import rrfc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_result_kind,
    input logic [7:0]  o_payload_byte,
    input logic [7:0]  o_srv_addr,
    input logic [7:0]  o_data_len,
    input logic [7:0]  o_exc_code,
    input logic [1:0]  o_frame_status,
    input logic [8:0]  o_consumed_length,
    input logic [15:0] o_computed_crc
);

    // payload beat carries the data byte with status, address, CRC and consumed length zero
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_PAYLOAD |->
            o_frame_status == ST_OK && o_srv_addr == 8'h00 &&
            o_computed_crc == 16'h0000 && o_consumed_length == 9'd0)
        else $error("payload beat carries status fields");

    a_exc_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_STATUS && o_frame_status == ST_EXCEPTION |->
            o_data_len == 8'h00 && o_consumed_length == 9'(EXC_CONSUME))
        else $error("exception status inconsistent");

    a_ok_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_STATUS && o_frame_status == ST_OK |->
            o_exc_code == 8'h00 &&
            o_consumed_length == 9'(o_data_len) + 9'(HDR_BYTES + TRL_BYTES))
        else $error("ok status with wrong consumed length");

    a_bad_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_STATUS &&
        (o_frame_status == ST_MALFORMED || o_frame_status == ST_CRC_ERR) |->
            o_consumed_length == 9'd0)
        else $error("failed frame reports consumed length");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_payload_byte) &&
            $stable(o_computed_crc) && $stable(o_frame_status))
        else $error("stalled result beat changed");

endmodule

bind rtu_response_frame_checker_unit rrfc_checker u_rrfc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_result_kind     (o_result_kind),
    .o_payload_byte    (o_payload_byte),
    .o_srv_addr        (o_srv_addr),
    .o_data_len        (o_data_len),
    .o_exc_code        (o_exc_code),
    .o_frame_status    (o_frame_status),
    .o_consumed_length (o_consumed_length),
    .o_computed_crc    (o_computed_crc)
);

// ===== dv/tb_rtu_response_frame_checker_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtu_response_frame_checker_unit - self-checking bench for the frame checker
// Feeds response frames byte by byte under random back-pressure and compares
// every payload and status beat against a cycle-free frame predictor.
// ----------------------------------------------------------------------------
module tb_rtu_response_frame_checker_unit;
    import rrfc_pkg::*;

    localparam int unsigned MAX_BYTES   = DEF_MAX_FRAME_BYTES;
    localparam int unsigned RAND_BYTES  = 1950;
    localparam int unsigned CYCLE_LIMIT = 250000;
    localparam int unsigned TAIL_CYCLES = 20;
    localparam logic [15:0] CRC_SEED    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    typedef logic [7:0] t_bytes [$];

    // one input beat waiting to be sent; hold_off makes the sender wait
    // until every outstanding result has been taken before offering it
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold_off;
    } t_rx_beat;

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_ready;
    logic [7:0]  i_rx_byte        = 8'h00;
    logic        i_end_of_frame   = 1'b0;
    logic        o_valid;
    logic        i_ready          = 1'b0;
    logic        o_result_kind;
    logic [7:0]  o_payload_byte;
    logic [7:0]  o_srv_addr;
    logic [7:0]  o_fn_code;
    logic [7:0]  o_data_len;
    logic [7:0]  o_exc_code;
    logic [1:0]  o_frame_status;
    logic [8:0]  o_consumed_length;
    logic [15:0] o_computed_crc;

    rtu_response_frame_checker_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_rx_byte         (i_rx_byte),
        .i_end_of_frame    (i_end_of_frame),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_result_kind     (o_result_kind),
        .o_payload_byte    (o_payload_byte),
        .o_srv_addr        (o_srv_addr),
        .o_fn_code         (o_fn_code),
        .o_data_len        (o_data_len),
        .o_exc_code        (o_exc_code),
        .o_frame_status    (o_frame_status),
        .o_consumed_length (o_consumed_length),
        .o_computed_crc    (o_computed_crc)
    );

    // ------------------------------------------------------------------------
    // Clock and cycle counter
    // ------------------------------------------------------------------------
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    int unsigned cyc_cnt = 0;
    always @(posedge i_clk) cyc_cnt <= cyc_cnt + 1;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_rx_beat    byte_stream_q [$];   // bytes still to be offered
    t_result     due_results   [$];   // predicted beats, oldest first
    int unsigned bytes_queued  = 0;
    int unsigned bytes_taken   = 0;
    int unsigned err_cnt       = 0;

    // predictor's own copy of the frame state
    int unsigned fr_pos;
    logic [15:0] fr_crc;
    logic [7:0]  fr_prev [2];         // [0] newest byte
    logic [7:0]  fr_addr;
    logic [7:0]  fr_func;
    logic [7:0]  fr_cnt;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // reflected CRC-16, one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] v;
        v = acc ^ {8'h00, d};
        repeat (8) v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        return v;
    endfunction

    function automatic void frame_clear();
        fr_pos     = 0;
        fr_crc     = CRC_SEED;
        fr_prev[0] = 8'h00;
        fr_prev[1] = 8'h00;
        fr_addr    = 8'h00;
        fr_func    = 8'h00;
        fr_cnt     = 8'h00;
    endfunction

    // Advance the frame state by one accepted byte. The CRC lags two bytes
    // behind so that, on the final byte, it covers everything but the trailer.
    function automatic void frame_track(input logic [7:0] b, input logic last,
                                        output bit emit, output t_result r);
        int unsigned p;
        int unsigned flen;
        int unsigned need;
        logic [15:0] trailer;
        bit          exc;
        p    = fr_pos;
        r    = '0;
        emit = 1'b0;
        if (p == 0) fr_addr = b;
        else if (p == 1) fr_func = b;
        else if (p == 2) fr_cnt = b;
        if (p >= 2) fr_crc = crc_byte(fr_crc, fr_prev[1]);
        exc = (fr_func & EXC_MASK) != 8'h00;
        if (!last) begin
            // payload window, closed once the position count saturates
            if (p >= HDR_BYTES && p < MAX_BYTES && !exc && p < HDR_BYTES + fr_cnt) begin
                emit           = 1'b1;
                r.kind         = KIND_PAYLOAD;
                r.payload_byte = b;
            end
            fr_prev[1] = fr_prev[0];
            fr_prev[0] = b;
            if (fr_pos < MAX_BYTES) fr_pos++;
        end else begin
            flen    = (p + 1 > MAX_BYTES) ? MAX_BYTES : p + 1;
            need    = HDR_BYTES + TRL_BYTES + fr_cnt;
            trailer = {b, fr_prev[0]};
            emit           = 1'b1;
            r.kind         = KIND_STATUS;
            r.srv_addr     = fr_addr;
            r.fn_code      = fr_func;
            r.data_len     = exc ? 8'h00 : fr_cnt;
            r.exc_code     = exc ? fr_cnt : 8'h00;
            r.computed_crc = fr_crc;
            if (flen < MIN_FRAME) begin
                r.status = ST_MALFORMED;
            end else if (exc) begin
                r.status          = ST_EXCEPTION;
                r.consumed_length = 9'(EXC_CONSUME);
            end else if (flen < need) begin
                r.status = ST_MALFORMED;
            end else if (fr_crc != trailer) begin
                r.status = ST_CRC_ERR;
            end else begin
                r.status          = ST_OK;
                r.consumed_length = 9'(need);
            end
            frame_clear();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Frame building
    // ------------------------------------------------------------------------
    function automatic t_bytes crc_append(input t_bytes f);
        logic [15:0] c;
        c = CRC_SEED;
        foreach (f[i]) c = crc_byte(c, f[i]);
        f.push_back(c[7:0]);
        f.push_back(c[15:8]);
        return f;
    endfunction

    // header plus payload of cnt bytes and extra surplus bytes, no trailer
    function automatic t_bytes normal_body(input int unsigned cnt, input int unsigned extra);
        t_bytes f;
        f.push_back(8'($urandom_range(0, 255)));
        f.push_back(8'($urandom_range(0, 127)));
        f.push_back(8'(cnt));
        repeat (cnt + extra) f.push_back(8'($urandom_range(0, 255)));
        return f;
    endfunction

    // mostly short payloads, the odd one up to the full count range
    function automatic int unsigned pick_count();
        return ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16);
    endfunction

    task automatic queue_frame(input t_bytes f, input bit hold_off);
        t_rx_beat bt;
        foreach (f[i]) begin
            bt.data     = f[i];
            bt.last     = (i == f.size() - 1);
            bt.hold_off = hold_off && (i == 0);
            byte_stream_q.push_back(bt);
            bytes_queued++;
        end
    endtask

    // frame longer than MAX_BYTES, past where the position count saturates, trailer still valid
    function automatic t_bytes long_frame();
        int unsigned cnt;
        int unsigned r;
        cnt = $urandom_range(0, 255);
        r   = $urandom_range(1, 8);
        return crc_append(normal_body(cnt, (cnt > 252) ? r : 252 - cnt + r));
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers queued bytes, with a random gap drawn after each beat
    // ------------------------------------------------------------------------
    int unsigned tx_gap   = 0;
    bit          tx_burst = 1'b0;     // stretch with no gaps

    always @(posedge i_clk) begin : drv
        t_rx_beat nb;
        t_result  want;
        bit       emit;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                frame_track(i_rx_byte, i_end_of_frame, emit, want);
                if (emit) due_results.push_back(want);
                bytes_taken++;
            end
            if (!i_valid || o_ready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (byte_stream_q.size() != 0 &&
                             !(byte_stream_q[0].hold_off && due_results.size() != 0)) begin
                    nb = byte_stream_q.pop_front();
                    i_valid        <= 1'b1;
                    i_rx_byte      <= nb.data;
                    i_end_of_frame <= nb.last;
                    tx_gap = tx_burst ? 0 : $urandom_range(0, 5);
                    if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes result beats, stalls at random after each one
    // ------------------------------------------------------------------------
    int unsigned rx_wait  = 0;
    bit          rx_burst = 1'b0;

    task automatic cmp_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : mon
        t_result want;
        logic    nrdy;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            nrdy = 1'b1;
            if (o_valid && i_ready) begin
                if (due_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result beat expected none got kind %0h", $time,
                             o_result_kind);
                end else begin
                    want = due_results.pop_front();
                    cmp_field("result_kind",     16'(want.kind),            16'(o_result_kind));
                    cmp_field("payload_byte",    16'(want.payload_byte),    16'(o_payload_byte));
                    cmp_field("srv_addr",        16'(want.srv_addr),        16'(o_srv_addr));
                    cmp_field("fn_code",         16'(want.fn_code),         16'(o_fn_code));
                    cmp_field("data_len",        16'(want.data_len),        16'(o_data_len));
                    cmp_field("exc_code",        16'(want.exc_code),        16'(o_exc_code));
                    cmp_field("frame_status",    16'(want.status),          16'(o_frame_status));
                    cmp_field("consumed_length", 16'(want.consumed_length), 16'(o_consumed_length));
                    cmp_field("computed_crc",    want.computed_crc,         o_computed_crc);
                end
                rx_wait = rx_burst ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
                nrdy = (rx_wait == 0);
            end else if (rx_wait != 0) begin
                rx_wait--;
                nrdy = (rx_wait == 0);
            end
            i_ready <= nrdy;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin : stim
        t_bytes      f;
        int unsigned rand_start;
        int unsigned sel;
        int unsigned cnt;
        int unsigned n;
        int unsigned k;
        frame_clear();

        // short headers: one, two and three bytes, CRC never folded below three
        queue_frame('{8'hFF}, 1'b0);
        queue_frame('{8'h00, 8'hFF}, 1'b0);
        queue_frame('{8'h11, 8'h03, 8'h02}, 1'b0);
        // exception frame with a bogus trailer, CRC must be ignored
        queue_frame('{8'h01, 8'h83, 8'h02, 8'h00, 8'h00}, 1'b0);
        // clean frame, payload at the byte extremes
        queue_frame(crc_append('{8'hFF, 8'h03, 8'h02, 8'h00, 8'hFF}), 1'b0);
        // zero count with one surplus byte before the trailer
        queue_frame(crc_append('{8'h00, 8'h04, 8'h00, 8'h5A}), 1'b0);

        // random part; the first frame waits for the pipe to drain
        rand_start = bytes_queued;
        queue_frame(long_frame(), 1'b1);
        while (bytes_queued - rand_start < RAND_BYTES) begin
            sel = $urandom_range(0, 99);
            cnt = pick_count();
            if (sel < 50) begin
                f = crc_append(normal_body(cnt, 0));
            end else if (sel < 60) begin
                f = crc_append(normal_body(cnt, $urandom_range(1, 4)));
            end else if (sel < 71) begin
                // single bit error anywhere, trailer included
                f = crc_append(normal_body(cnt, 0));
                k = $urandom_range(0, f.size() - 1);
                f[k] = f[k] ^ (8'h01 << $urandom_range(0, 7));
            end else if (sel < 79) begin
                f = {};
                f.push_back(8'($urandom_range(0, 255)));
                f.push_back(8'($urandom_range(128, 255)));
                f.push_back(8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 3)) f.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 1) begin
                    f = crc_append(f);
                end else begin
                    f.push_back(8'($urandom_range(0, 255)));
                    f.push_back(8'($urandom_range(0, 255)));
                end
            end else if (sel < 87) begin
                // frame cut short
                f = crc_append(normal_body(cnt, 0));
                n = $urandom_range(1, f.size() - 1);
                while (f.size() > n) void'(f.pop_back());
            end else if (sel < 99) begin
                f = {};
                repeat ($urandom_range(1, 8)) f.push_back(8'($urandom_range(0, 255)));
            end else begin
                f = long_frame();
            end
            queue_frame(f, $urandom_range(0, 39) == 0);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken != bytes_queued) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        wait (cyc_cnt >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rrfc_pkg.sv
hw/rtl/rrfc_in_stage.sv
hw/rtl/rrfc_frame_core.sv
hw/rtl/rrfc_out_stage.sv
hw/rtl/rtu_response_frame_checker_unit.sv
hw/rtl/rrfc_checker.sv
dv/tb_rtu_response_frame_checker_unit.sv
